/* rtl/ralm_pkg.sv */
`default_nettype none
package ralm_pkg;

   localparam int RSSI_WIDTH_DEF = 8;
   localparam int LEVEL_W = 7;
   localparam int BEEP_W = 10;
   localparam int REG_W = 8;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_START = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_START = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CEIL_START = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPAN = 4'd3;

   localparam logic signed [REG_W-1:0] PEAK_START_RST = -8'sd120;
   localparam logic signed [REG_W-1:0] FLOOR_START_RST = -8'sd40;
   localparam logic signed [REG_W-1:0] CEIL_START_RST = -8'sd100;
   localparam logic [REG_W-1:0] MIN_SPAN_RST = 8'd10;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_RECAL = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
   localparam logic [BEEP_W-1:0] BEEP_BASE = 10'd1000;
   localparam logic [BEEP_W-1:0] BEEP_MIN = 10'd50;

   typedef struct packed {
      logic start;
      logic req_type;
   } trk_ctl_type;

   typedef struct packed {
      logic signed [REG_W-1:0] peak_start;
      logic signed [REG_W-1:0] floor_start;
      logic signed [REG_W-1:0] ceil_start;
   } trk_cfg_type;

endpackage
`default_nettype wire

/* rtl/ralm_tracker.sv */
`default_nettype none
module ralm_tracker #(
   parameter int RSSI_WIDTH = ralm_pkg::RSSI_WIDTH_DEF,
   parameter int TRK_W = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ralm_pkg::trk_ctl_type         ctl,
   input  wire ralm_pkg::trk_cfg_type         cfg,
   input  wire logic signed [RSSI_WIDTH-1:0]  raw_rssi,
   output logic signed [RSSI_WIDTH-1:0]       avg_out,
   output logic signed [TRK_W-1:0]            peak_out,
   output logic signed [TRK_W-1:0]            floor_out,
   output logic signed [TRK_W-1:0]            ceil_out
);
   import ralm_pkg::*;

   localparam int SUM_W = RSSI_WIDTH + 3;

   logic signed [RSSI_WIDTH-1:0] avg_ff, avg_in;
   logic seeded_ff, seeded_in;
   logic signed [TRK_W-1:0] peak_ff, peak_in;
   logic signed [TRK_W-1:0] floor_ff, floor_in;
   logic signed [TRK_W-1:0] ceil_ff, ceil_in;

   logic signed [RSSI_WIDTH-1:0] base;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] adj;
   logic signed [SUM_W-1:0] quarter;
   logic signed [RSSI_WIDTH-1:0] new_avg;
   logic signed [TRK_W-1:0] new_avg_x;
   logic signed [TRK_W-1:0] pk0, fl0, cl0;

   always_comb begin
      base = seeded_ff ? avg_ff : raw_rssi;
      sum = (SUM_W'(base) <<< 1) + SUM_W'(base) + SUM_W'(raw_rssi);
      adj = sum[SUM_W-1] ? sum + SUM_W'(3) : sum;
      quarter = adj >>> 2;
      new_avg = quarter[RSSI_WIDTH-1:0];
      new_avg_x = TRK_W'(new_avg);
      pk0 = seeded_ff ? peak_ff : TRK_W'(cfg.peak_start);
      fl0 = seeded_ff ? floor_ff : TRK_W'(cfg.floor_start);
      cl0 = seeded_ff ? ceil_ff : TRK_W'(cfg.ceil_start);

      avg_in = avg_ff;
      seeded_in = seeded_ff;
      peak_in = peak_ff;
      floor_in = floor_ff;
      ceil_in = ceil_ff;
      if (ctl.start) begin
         if (ctl.req_type == REQ_SAMPLE) begin
            avg_in = new_avg;
            seeded_in = 1'b1;
            peak_in = (new_avg_x > pk0) ? new_avg_x : pk0;
            floor_in = (new_avg_x < fl0) ? new_avg_x : fl0;
            ceil_in = (new_avg_x > cl0) ? new_avg_x : cl0;
         end else if (seeded_ff) begin
            peak_in = TRK_W'(cfg.peak_start);
            floor_in = TRK_W'(avg_ff);
            ceil_in = TRK_W'(avg_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
         seeded_ff <= 1'b0;
         peak_ff <= TRK_W'(PEAK_START_RST);
         floor_ff <= TRK_W'(FLOOR_START_RST);
         ceil_ff <= TRK_W'(CEIL_START_RST);
      end else begin
         avg_ff <= avg_in;
         seeded_ff <= seeded_in;
         peak_ff <= peak_in;
         floor_ff <= floor_in;
         ceil_ff <= ceil_in;
      end
   end

   assign avg_out = avg_ff;
   assign peak_out = peak_ff;
   assign floor_out = floor_ff;
   assign ceil_out = ceil_ff;

endmodule
`default_nettype wire

/* rtl/ralm_divider.sv */
`default_nettype none
module ralm_divider #(
   parameter int NUM_W = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [NUM_W-1:0]              dividend,
   input  wire logic [NUM_W-1:0]              divisor,
   output logic                               done,
   output logic [ralm_pkg::LEVEL_W-1:0]       quotient
);
   import ralm_pkg::*;

   localparam int CNT_W = $clog2(LEVEL_W);

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] dsr_ff, dsr_in;
   logic [LEVEL_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic fits;

   always_comb begin
      fits = rem_ff >= dsr_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend;
         dsr_in = divisor << (LEVEL_W - 1);
         quo_in = '0;
         cnt_in = CNT_W'(LEVEL_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsr_ff;
         end
         quo_in = {quo_ff[LEVEL_W-2:0], fits};
         dsr_in = dsr_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

/* rtl/rssi_autorange_level_meter.sv */
`default_nettype none
// Each accepted word is a raw RSSI sample or a recalibrate request, and each one yields exactly
// one result word with the moving average, the 0..100 level, the peak, floor and ceiling, and
// the beep interval. The block handles one word at a time and holds req_tready low while it
// works: a word whose level clamps to 0 or 100 skips the divider, and any other word runs the
// seven steps of the restoring subtract unit that scales the level; the block also waits while
// the previous result is still waiting on the result side.
module rssi_autorange_level_meter #(
   parameter int RSSI_WIDTH = ralm_pkg::RSSI_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // raw_rssi
   input  wire logic [((RSSI_WIDTH+7)/8)*8-1:0]     req_tdata,
   // req_type
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // smoothed_rssi, level_pct, peak_level, floor_level, ceil_level, beep_interval_ms
   output logic [((RSSI_WIDTH+41+7)/8)*8-1:0]       rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ralm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ralm_pkg::REG_W-1:0]          csr_data
);
   import ralm_pkg::*;

   localparam int TRK_W = (RSSI_WIDTH > REG_W) ? RSSI_WIDTH : REG_W;
   localparam int DIF_W = TRK_W + 1;
   localparam int NUM_W = DIF_W + LEVEL_W;
   localparam int RSP_W = ((RSSI_WIDTH + 41 + 7) / 8) * 8;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_DIV = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   trk_cfg_type cfg_ff, cfg_in;
   logic [REG_W-1:0] min_span_ff, min_span_in;

   trk_ctl_type trk_ctl;
   logic req_fire;
   logic signed [RSSI_WIDTH-1:0] avg;
   logic signed [TRK_W-1:0] peak, floor_v, ceil_v;

   logic [REG_W-1:0] ms8;
   logic signed [DIF_W-1:0] ms, raw_span, span, diff;
   logic [NUM_W-1:0] diff_ext, dividend, divisor;
   logic div_start, div_done;
   logic [LEVEL_W-1:0] quotient;
   logic [BEEP_W-1:0] lvl_ext, beep_raw, beep;
   logic rsp_free;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      min_span_in = min_span_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PEAK_START: cfg_in.peak_start = csr_data;
            CSR_FLOOR_START: cfg_in.floor_start = csr_data;
            CSR_CEIL_START: cfg_in.ceil_start = csr_data;
            CSR_MIN_SPAN: min_span_in = csr_data;
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign trk_ctl.start = req_fire;
   assign trk_ctl.req_type = req_tuser;

   ralm_tracker #(
      .RSSI_WIDTH(RSSI_WIDTH),
      .TRK_W(TRK_W)
   ) u_tracker (
      .clock(clock),
      .reset(reset),
      .ctl(trk_ctl),
      .cfg(cfg_ff),
      .raw_rssi(req_tdata[RSSI_WIDTH-1:0]),
      .avg_out(avg),
      .peak_out(peak),
      .floor_out(floor_v),
      .ceil_out(ceil_v)
   );

   always_comb begin
      ms8 = (min_span_ff == '0) ? REG_W'(1) : min_span_ff;
      ms = DIF_W'(ms8);
      raw_span = DIF_W'(ceil_v) - DIF_W'(floor_v);
      span = (raw_span < ms) ? ms : raw_span;
      diff = DIF_W'(avg) - DIF_W'(floor_v);
      diff_ext = NUM_W'(unsigned'(diff));
      dividend = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
      divisor = NUM_W'(unsigned'(span));
   end

   ralm_divider #(
      .NUM_W(NUM_W)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(dividend),
      .divisor(divisor),
      .done(div_done),
      .quotient(quotient)
   );

   always_comb begin
      lvl_ext = BEEP_W'(lvl_ff);
      beep_raw = BEEP_BASE - (lvl_ext << 3) - lvl_ext;
      beep = (beep_raw < BEEP_MIN) ? BEEP_MIN : beep_raw;
      rsp_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in = state_ff;
      lvl_in = lvl_ff;
      div_start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (diff[DIF_W-1] || (diff == '0)) begin
               lvl_in = '0;
               state_in = ST_DONE;
            end else if (diff >= span) begin
               lvl_in = LEVEL_MAX;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               lvl_in = quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = RSP_W'({beep, ceil_v[REG_W-1:0], floor_v[REG_W-1:0],
                                     peak[REG_W-1:0], lvl_ff, avg});
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff.peak_start <= PEAK_START_RST;
         cfg_ff.floor_start <= FLOOR_START_RST;
         cfg_ff.ceil_start <= CEIL_START_RST;
         min_span_ff <= MIN_SPAN_RST;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff <= cfg_in;
         min_span_ff <= min_span_in;
      end
      lvl_ff <= lvl_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import ralm_pkg::*;

   localparam int RSSI_W = RSSI_WIDTH_DEF;
   localparam int REQ_W = ((RSSI_W + 7) / 8) * 8;
   localparam int RSP_W = ((RSSI_W + 41 + 7) / 8) * 8;
   localparam int PAD_W = RSP_W - RSSI_W - 41;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEMS_PER_PHASE = 400;
   localparam int PHASES = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'd9;

   typedef struct packed {
      logic rtype;
      logic [RSSI_W-1:0] raw;
   } meter_req_type;

   // Field order from the lowest bit up: smoothed_rssi, level_pct, peak_level,
   // floor_level, ceil_level, beep_interval_ms, zero fill.
   typedef struct packed {
      logic [PAD_W-1:0] pad;
      logic [BEEP_W-1:0] beep;
      logic [REG_W-1:0] cel;
      logic [REG_W-1:0] flr;
      logic [REG_W-1:0] peak;
      logic [LEVEL_W-1:0] level;
      logic [RSSI_W-1:0] avg;
   } meter_reading_type;

   typedef enum {RX_FREE, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tuser = REQ_SAMPLE;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_data = '0;

   meter_req_type pending_items[$];
   meter_reading_type expected_readings[$];
   meter_req_type drv_item;
   meter_reading_type got_reading;
   meter_reading_type want_reading;
   int burst_left = 0;
   int gap_left = 0;
   rx_mode_type rx_mode = RX_FREE;
   int rx_mode_left = 0;
   int idle_cycles = 0;
   int failures = 0;

   // Shadow of the meter: configuration and tracking state.
   int cfg_peak_start = PEAK_START_RST;
   int cfg_floor_start = FLOOR_START_RST;
   int cfg_ceil_start = CEIL_START_RST;
   int cfg_min_span = MIN_SPAN_RST;
   int avg_dbm = 0;
   bit seeded = 1'b0;
   int peak_dbm = PEAK_START_RST;
   int floor_dbm = FLOOR_START_RST;
   int ceil_dbm = CEIL_START_RST;

   rssi_autorange_level_meter #(.RSSI_WIDTH(RSSI_W)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic meter_reading_type meter_step(input logic rtype,
                                                    input logic signed [RSSI_W-1:0] raw);
      int raw_dbm;
      int span;
      int min_span;
      int level;
      int beep;
      meter_reading_type r;
      raw_dbm = raw;
      if (rtype == REQ_SAMPLE) begin
         if (!seeded) begin
            avg_dbm = raw_dbm;
            seeded = 1'b1;
            peak_dbm = cfg_peak_start;
            floor_dbm = cfg_floor_start;
            ceil_dbm = cfg_ceil_start;
         end
         avg_dbm = (avg_dbm * 3 + raw_dbm) / 4;
         if (avg_dbm > peak_dbm) peak_dbm = avg_dbm;
         if (avg_dbm < floor_dbm) floor_dbm = avg_dbm;
         if (avg_dbm > ceil_dbm) ceil_dbm = avg_dbm;
      end else if (seeded) begin
         peak_dbm = cfg_peak_start;
         floor_dbm = avg_dbm;
         ceil_dbm = avg_dbm;
      end
      min_span = (cfg_min_span == 0) ? 1 : cfg_min_span;
      span = ceil_dbm - floor_dbm;
      if (span < min_span) span = min_span;
      level = ((avg_dbm - floor_dbm) * 100) / span;
      if (level < 0) level = 0;
      if (level > LEVEL_MAX) level = LEVEL_MAX;
      beep = BEEP_BASE - level * 9;
      if (beep < BEEP_MIN) beep = BEEP_MIN;
      r.pad = '0;
      r.avg = avg_dbm[RSSI_W-1:0];
      r.level = level[LEVEL_W-1:0];
      r.peak = peak_dbm[REG_W-1:0];
      r.flr = floor_dbm[REG_W-1:0];
      r.cel = ceil_dbm[REG_W-1:0];
      r.beep = beep[BEEP_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic queue_item(input logic rtype, input logic [RSSI_W-1:0] raw);
      meter_req_type item;
      item.rtype = rtype;
      item.raw = raw;
      pending_items.push_back(item);
   endtask

   // Leaves csr_valid high; the caller lowers it after its last write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PEAK_START: cfg_peak_start = $signed(val);
         CSR_FLOOR_START: cfg_floor_start = $signed(val);
         CSR_CEIL_START: cfg_ceil_start = $signed(val);
         CSR_MIN_SPAN: cfg_min_span = val;
         default: ;
      endcase
   endtask

   task automatic write_settings(input logic [REG_W-1:0] peak_start,
                                 input logic [REG_W-1:0] floor_start,
                                 input logic [REG_W-1:0] ceil_start,
                                 input logic [REG_W-1:0] min_span);
      write_csr(CSR_PEAK_START, peak_start);
      write_csr(CSR_FLOOR_START, floor_start);
      write_csr(CSR_CEIL_START, ceil_start);
      write_csr(CSR_MIN_SPAN, min_span);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_readings.size() != 0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= REQ_SAMPLE;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            drv_item = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= drv_item.raw;
            req_tuser <= drv_item.rtype;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_mode <= RX_FREE;
         rx_mode_left <= 64;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(3));
            rx_mode_left <= $urandom_range(32, 256);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            RX_FREE: rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= 1'($urandom_range(1));
            RX_SPARSE: rsp_tready <= ($urandom_range(7) == 0);
            default: rsp_tready <= rx_mode_left[2];
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(meter_step(req_tuser, req_tdata[RSSI_W-1:0]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got_reading = rsp_tdata;
            if (expected_readings.size() == 0) begin
               $error("Result word with no expectation pending: %h", rsp_tdata);
               failures++;
            end else begin
               want_reading = expected_readings.pop_front();
               check_field("smoothed_rssi", $signed(want_reading.avg), $signed(got_reading.avg));
               check_field("level_pct", want_reading.level, got_reading.level);
               check_field("peak_level", $signed(want_reading.peak), $signed(got_reading.peak));
               check_field("floor_level", $signed(want_reading.flr), $signed(got_reading.flr));
               check_field("ceil_level", $signed(want_reading.cel), $signed(got_reading.cel));
               check_field("beep_interval_ms", want_reading.beep, got_reading.beep);
               check_field("zero_fill", want_reading.pad, got_reading.pad);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int center;
      int raw_dbm;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // A recalibrate before any sample reports the reset state.
      queue_item(REQ_RECAL, 8'h00);
      drain();

      write_settings(8'sd127, 8'sd127, -8'sd128, 8'd0);
      write_csr(CSR_UNMAPPED, 8'h55);
      csr_valid <= 1'b0;

      queue_item(REQ_SAMPLE, -8'sd128);
      queue_item(REQ_SAMPLE, 8'sd127);
      queue_item(REQ_SAMPLE, 8'sd127);
      queue_item(REQ_SAMPLE, 8'sd127);
      queue_item(REQ_SAMPLE, -8'sd128);
      queue_item(REQ_SAMPLE, -8'sd128);
      queue_item(REQ_RECAL, 8'hff);
      queue_item(REQ_SAMPLE, 8'sd0);
      queue_item(REQ_SAMPLE, -8'sd1);
      queue_item(REQ_SAMPLE, 8'sd1);
      queue_item(REQ_SAMPLE, 8'sd127);
      queue_item(REQ_RECAL, 8'h80);
      queue_item(REQ_RECAL, 8'h7f);
      queue_item(REQ_SAMPLE, 8'h55);
      queue_item(REQ_SAMPLE, 8'haa);
      repeat (3) queue_item(REQ_SAMPLE, -8'sd128);
      repeat (3) queue_item(REQ_SAMPLE, 8'sd127);
      queue_item(REQ_SAMPLE, -8'sd3);
      queue_item(REQ_SAMPLE, -8'sd5);
      drain();

      center = -70;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: write_settings(-8'sd128, -8'sd128, 8'sd127, 8'd255);
            1: write_settings(8'sd0, 8'sd0, 8'sd0, 8'd1);
            2: write_settings(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom),
                              REG_W'($urandom_range(1, 255)));
            3: write_settings(8'sd127, REG_W'($urandom), REG_W'($urandom), 8'd0);
            default: write_settings(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom),
                                    REG_W'($urandom_range(40)));
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(15) == 0) begin
               queue_item(REQ_RECAL, RSSI_W'($urandom));
            end else if ($urandom_range(1) == 0) begin
               queue_item(REQ_SAMPLE, RSSI_W'($urandom));
            end else begin
               // Samples that wander around a slowly moving level.
               center += int'($urandom_range(6)) - 3;
               if (center < -128) center = -128;
               if (center > 127) center = 127;
               raw_dbm = center + int'($urandom_range(10)) - 5;
               if (raw_dbm < -128) raw_dbm = -128;
               if (raw_dbm > 127) raw_dbm = 127;
               queue_item(REQ_SAMPLE, raw_dbm[RSSI_W-1:0]);
            end
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
